// File: design/hcrt_pkg.sv
package hcrt_pkg;
  localparam int MaxNodesDefault = 64;
  localparam int CmdW = 2;
  localparam int IdW = 16;
  localparam int StatusW = 3;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_NEXT_HOP = 2'd2;
  localparam logic [1:0] CMD_DEPTH = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_ID = 3'd1;
  localparam logic [2:0] ST_NO_TABLE = 3'd2;
  localparam logic [2:0] ST_NOT_ASSOC = 3'd3;
  localparam logic [2:0] ST_UNREACH = 3'd4;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SINK_NODE = 2'd1;
  localparam logic [1:0] REG_OWN_ADDRESS = 2'd2;

  localparam logic [15:0] UNASSOCIATED = 16'hFFFF;

  typedef struct packed {
    logic [1:0] command;
    logic [15:0] node_a;
    logic [15:0] node_b;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic changed;
    logic [5:0] next_hop;
    logic [5:0] depth;
  } rsp_t;
endpackage

// File: design/hcrt_stream_if.sv
interface hcrt_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/hop_count_route_table_engine.sv
// Hop-count route table engine. One command is handled at a time; in_ch is
// ready only while the engine is idle and no result waits in the output
// register. After reset the link matrix is cleared one row a cycle, so the
// input stays not ready until every row is cleared. Add and remove keep
// a link matrix (one row of MAX_NODES bits per source node, held in a memory
// with one registered read port); a change triggers a rebuild. The rebuild
// first clears the distance and parent tables, one entry a cycle, then runs
// relaxation sweeps. Each pair (i, j) goes through the shared compare unit,
// after two row loads of the link memory per source node, and a rebuild
// runs at most as many sweeps as the tree depth plus one. A pair uses a link
// in either direction, so sweeps read row i and row j of the memory. Queries
// walk the parent table, a parent read and a step state per hop, at most
// MAX_NODES+1 hops. Commands rejected by a check, and a remove before any
// add, go from the check state straight to the done state; an add or remove
// that changes nothing passes the row read and link states on the way.
// Configuration writes must only arrive while idle.
module hop_count_route_table_engine #(
  parameter int MAX_NODES = hcrt_pkg::MaxNodesDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  hcrt_stream_if.sink in_ch,
  hcrt_stream_if.source out_ch
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int DW = $clog2(MAX_NODES + 2) + 1;
  localparam int SW = $clog2(MAX_NODES + 2);
  localparam logic [DW-1:0] DINF = '1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_ROWRD = 4'd2;
  localparam logic [3:0] S_LINK = 4'd3;
  localparam logic [3:0] S_CLEAR = 4'd4;
  localparam logic [3:0] S_ROWI = 4'd5;
  localparam logic [3:0] S_ROWJ = 4'd6;
  localparam logic [3:0] S_RELAX = 4'd7;
  localparam logic [3:0] S_WRD = 4'd8;
  localparam logic [3:0] S_WSTEP = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;
  localparam logic [3:0] S_INIT = 4'd11;

  logic [3:0] state;
  logic [6:0] node_count;
  logic [5:0] sink_node;
  logic [15:0] own_address;
  logic graph_ready;

  logic [MAX_NODES-1:0] link_mem [MAX_NODES];
  logic [DW-1:0] dist_mem [MAX_NODES];
  logic [NW:0] par_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_rd;
  logic [MAX_NODES-1:0] row_i;
  logic [NW:0] par_rd;

  hcrt_pkg::req_t req;
  hcrt_pkg::rsp_t rsp;
  logic out_full;

  logic [CW-1:0] n_live;
  logic [NW-1:0] ci, cj;
  logic [NW-1:0] cur;
  logic [SW-1:0] steps;
  logic moved;
  logic [DW-1:0] di;
  logic a_ok, b_ok;
  logic sink_ok;

  always_comb begin
    if (node_count == 7'd0) n_live = CW'(1);
    else if (32'(node_count) > MAX_NODES) n_live = CW'(MAX_NODES);
    else n_live = CW'(node_count);
  end

  assign a_ok = 32'(req.node_a) < 32'(n_live);
  assign b_ok = 32'(req.node_b) < 32'(n_live);
  assign sink_ok = 32'(sink_node) < 32'(n_live);
  assign in_ch.ready = (state == S_IDLE) && !out_full;
  assign out_ch.valid = out_full;
  assign out_ch.data = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 7'd64;
      sink_node <= '0;
      own_address <= hcrt_pkg::UNASSOCIATED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcrt_pkg::REG_NODE_COUNT: node_count <= cfg_data[6:0];
        hcrt_pkg::REG_SINK_NODE: sink_node <= cfg_data[5:0];
        hcrt_pkg::REG_OWN_ADDRESS: own_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // Relaxation compare: the shared unit.
  logic [DW-1:0] dj;
  logic linked, relax;
  assign linked = row_i[cj] || row_rd[ci];
  assign relax = linked && (di != DINF) && (dj > di + DW'(1));

  logic [MAX_NODES-1:0] row_addr_wr;
  logic row_we;
  logic [NW-1:0] row_waddr;
  logic [NW-1:0] row_raddr;
  logic dist_we;
  logic [NW-1:0] dist_waddr;
  logic [DW-1:0] dist_wdata;
  logic [NW:0] par_wdata;
  logic [NW-1:0] dist_raddr;
  logic [NW-1:0] par_raddr;

  always_comb begin
    row_raddr = ci;
    if (state == S_CHECK || state == S_ROWRD) row_raddr = req.node_a[NW-1:0];
    else if (state == S_ROWJ) row_raddr = cj;
    else if (state == S_RELAX) row_raddr = NW'(32'(cj) + 1);
    par_raddr = cur;
    dist_raddr = (state == S_RELAX) ? NW'(32'(cj) + 1) : cj;
  end

  always_ff @(posedge clk) begin
    row_rd <= link_mem[row_raddr];
    par_rd <= par_mem[par_raddr];
    di <= dist_mem[ci];
    if (row_we) link_mem[row_waddr] <= row_addr_wr;
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
      par_mem[dist_waddr] <= par_wdata;
    end
  end
  always_ff @(posedge clk) begin
    dj <= dist_mem[dist_raddr];
  end

  always_comb begin
    row_we = 1'b0;
    row_waddr = req.node_a[NW-1:0];
    row_addr_wr = row_rd;
    row_addr_wr[req.node_b[NW-1:0]] = (req.command == hcrt_pkg::CMD_ADD);
    dist_we = 1'b0;
    dist_waddr = ci;
    dist_wdata = DINF;
    par_wdata = '1;
    if (state == S_INIT) begin
      row_we = 1'b1;
      row_waddr = ci;
      row_addr_wr = '0;
    end
    if (state == S_LINK && row_rd[req.node_b[NW-1:0]] != (req.command == hcrt_pkg::CMD_ADD))
      row_we = 1'b1;
    if (state == S_CLEAR) begin
      dist_we = 1'b1;
      dist_wdata = (32'(ci) == 32'(sink_node) && sink_ok) ? '0 : DINF;
    end
    if (state == S_RELAX && relax) begin
      dist_we = 1'b1;
      dist_waddr = cj;
      dist_wdata = di + DW'(1);
      par_wdata = {1'b0, ci};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ci <= '0;
      out_full <= 1'b0;
      graph_ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_full <= 1'b0;
      unique case (state)
        S_INIT: begin
          ci <= ci + NW'(1);
          if (32'(ci) == MAX_NODES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req <= in_ch.data;
            rsp <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cur <= req.node_a[NW-1:0];
          steps <= '0;
          unique case (req.command)
            hcrt_pkg::CMD_ADD: begin
              if (!a_ok || !b_ok) begin
                rsp.status <= hcrt_pkg::ST_BAD_ID;
                state <= S_DONE;
              end else begin
                graph_ready <= 1'b1;
                state <= S_ROWRD;
              end
            end
            hcrt_pkg::CMD_REMOVE: begin
              if (!graph_ready) state <= S_DONE;
              else if (!a_ok || !b_ok) begin
                rsp.status <= hcrt_pkg::ST_BAD_ID;
                state <= S_DONE;
              end else state <= S_ROWRD;
            end
            default: begin
              if (!a_ok) begin
                rsp.status <= hcrt_pkg::ST_BAD_ID;
                state <= S_DONE;
              end else if (!graph_ready) begin
                rsp.status <= hcrt_pkg::ST_NO_TABLE;
                state <= S_DONE;
              end else if (req.command == hcrt_pkg::CMD_NEXT_HOP &&
                           own_address == hcrt_pkg::UNASSOCIATED) begin
                rsp.status <= hcrt_pkg::ST_NOT_ASSOC;
                state <= S_DONE;
              end else begin
                rsp.status <= hcrt_pkg::ST_UNREACH;
                state <= S_WRD;
              end
            end
          endcase
        end
        S_ROWRD: state <= S_LINK;
        S_LINK: begin
          if (row_we) begin
            rsp.changed <= 1'b1;
            ci <= '0;
            state <= S_CLEAR;
          end else state <= S_DONE;
        end
        S_CLEAR: begin
          if (32'(ci) == MAX_NODES - 1) begin
            ci <= '0;
            cj <= '0;
            moved <= 1'b0;
            state <= S_ROWI;
          end else ci <= ci + NW'(1);
        end
        S_ROWI: state <= S_ROWJ;
        S_ROWJ: begin
          row_i <= row_rd;
          state <= S_RELAX;
        end
        S_RELAX: begin
          // di/dj read registered; relax of (ci,cj) updates entry cj.
          if (relax) moved <= 1'b1;
          if (32'(cj) + 1 < 32'(n_live)) begin
            cj <= cj + NW'(1);
          end else if (32'(ci) + 1 < 32'(n_live)) begin
            ci <= ci + NW'(1);
            cj <= '0;
            state <= S_ROWI;
          end else if (moved || relax) begin
            ci <= '0;
            cj <= '0;
            moved <= 1'b0;
            state <= S_ROWI;
          end else state <= S_DONE;
        end
        S_WRD: state <= S_WSTEP;
        S_WSTEP: begin
          steps <= steps + SW'(1);
          state <= S_WRD;
          if (32'(steps) > MAX_NODES) state <= S_DONE;
          else if (req.command == hcrt_pkg::CMD_DEPTH) begin
            // A parent left over from a larger node count may lie beyond it
            // and still be the sink.
            if (32'(cur) == 32'(sink_node)) begin
              rsp.status <= hcrt_pkg::ST_OK;
              rsp.depth <= (32'(steps) > 63) ? 6'd63 : 6'(steps);
              state <= S_DONE;
            end else if (32'(cur) >= 32'(n_live) || par_rd[NW]) state <= S_DONE;
            else cur <= par_rd[NW-1:0];
          end else begin
            if (!par_rd[NW] && 16'(par_rd) == own_address) begin
              rsp.status <= hcrt_pkg::ST_OK;
              rsp.next_hop <= 6'(cur);
              state <= S_DONE;
            end else if (par_rd[NW] || 32'(par_rd) >= 32'(n_live)) state <= S_DONE;
            else if (16'(par_rd) == {10'd0, sink_node}) state <= S_DONE;
            else cur <= par_rd[NW-1:0];
          end
        end
        S_DONE: begin
          if (!out_full || out_ch.ready) begin
            out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> !out_full)
    else $error("ready while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_full) |=> out_full)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_ch.ready) |=> $stable(rsp))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX && relax) |-> (di != DINF))
    else $error("relax from infinite");
endmodule
